### rtl/core/fixed_block_free_stack_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block free stack allocator
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_STACK_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_FREE_STACK_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain invariant
`define FBSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FBSA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define FBSA_ASSERT(lbl, prop, msg)
`define FBSA_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/fbsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsa_pkg
// Shared widths, codes and helpers for the free stack allocator.
// ----------------------------------------------------------------------------
package fbsa_pkg;

    localparam int DEF_MAX_BLOCKS       = 1024;
    localparam int DEF_MAX_OBJECT_WORDS = 1024;

    localparam int OFFSET_W   = 20;
    localparam int BYTES_W    = 13;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [BYTES_W-1:0] RESET_OBJECT_BYTES = 13'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT   = 1'd1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // ceil(bytes / 4), at least one, saturated at max_words
    function automatic int words_per_object(logic [BYTES_W-1:0] bytes, int max_words);
        int w;
        w = (int'(bytes) + 3) >> 2;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > max_words)
        begin
            w = max_words;
        end
        return w;
    endfunction

endpackage

### rtl/core/fbsa_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsa_stack_mem
// Single-port free index stack RAM, registered read data.
// ----------------------------------------------------------------------------
module fbsa_stack_mem #(
    parameter int DEPTH  = fbsa_pkg::DEF_MAX_BLOCKS,
    parameter int WIDTH  = 10,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  fbsa_pkg::mem_ctrl_t ctrl,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [WIDTH-1:0]    wdata,
    output logic [WIDTH-1:0]    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fbsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsa_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module fbsa_div #(
    parameter int DIVISOR_W = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fbsa_pkg::OFFSET_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output logic [fbsa_pkg::OFFSET_W-1:0] quotient,
    output fbsa_pkg::div_stat_t           stat
);

    localparam int STEPS = (fbsa_pkg::OFFSET_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]     q_reg;
    logic [DIVISOR_W:0]   r_reg;
    logic [DIVISOR_W-1:0] d_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [PAD_W-1:0]     q_next;
    logic [DIVISOR_W:0]   r_next;

    // two restoring steps per cycle
    always_comb
    begin
        r_next = r_reg;
        q_next = q_reg;
        for (int i = 0; i < 2; i++)
        begin
            r_next = {r_next[DIVISOR_W-1:0], q_next[PAD_W-1]};
            q_next = {q_next[PAD_W-2:0], 1'b0};
            if (r_next >= {1'b0, d_reg})
            begin
                r_next    = r_next - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= PAD_W'(dividend);
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg[fbsa_pkg::OFFSET_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/core/fixed_block_free_stack_allocator_top.sv
`timescale 1ns / 1ps
// Allocate: from accept through S_READ and S_MUL to S_FINISH, which loads the result
//   (S_READ skipped when the slot is untouched since restart, S_FINISH only when the
//   pool is empty). Free: S_DIV, where the divider retires two quotient bits per cycle
//   over a 20-bit offset, then S_WRITE and S_FINISH (S_FINISH only when stack is full).
// One transaction at a time; the next is accepted the cycle after the result is loaded.
// Reset: async, active low; no clearing pass - untouched stack entries read as their index.
// ----------------------------------------------------------------------------
// fixed_block_free_stack_allocator_top
// Fixed-size block pool kept as a stack of free block indices in one RAM.
// ----------------------------------------------------------------------------
`include "fixed_block_free_stack_allocator_top_macros.svh"

module fixed_block_free_stack_allocator_top #(
    parameter int MAX_OBJECT_WORDS = fbsa_pkg::DEF_MAX_OBJECT_WORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbsa_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [fbsa_pkg::OFFSET_W-1:0]   free_word_offset,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fbsa_pkg::STATUS_W-1:0]   status,
    output logic [fbsa_pkg::OFFSET_W-1:0]   block_word_offset,
    output logic [fbsa_pkg::COUNT_W-1:0]    free_blocks
);

    // stack depth is a power of two, so the index wraps by truncation
    localparam int  MAX_BLOCKS = fbsa_pkg::DEF_MAX_BLOCKS;
    localparam int  IDX_W      = $clog2(MAX_BLOCKS);
    localparam int  WORD_W     = $clog2(MAX_OBJECT_WORDS + 1);
    localparam int  DIV_W      = WORD_W;
    localparam int  PROD_W     = IDX_W + WORD_W;
    localparam int  CNT_W      = fbsa_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg;

    // Configuration derived values
    logic [WORD_W-1:0] words_reg;
    logic [CNT_W-1:0]  cap_reg;

    // Stack pointer and low-water mark. Every stack slot at or above
    // min_top_reg has been written since the last restart; slots below it
    // still hold their restart value, which is the slot number itself.
    logic [CNT_W-1:0]  top_reg;
    logic [CNT_W-1:0]  min_top_reg;

    logic [IDX_W-1:0]                    idx_reg;
    logic [fbsa_pkg::STATUS_W-1:0]       res_status_reg;
    logic [fbsa_pkg::OFFSET_W-1:0]       res_offset_reg;

    logic                                out_valid_reg;
    logic [fbsa_pkg::STATUS_W-1:0]       status_reg;
    logic [fbsa_pkg::OFFSET_W-1:0]       block_word_offset_reg;
    logic [CNT_W-1:0]                    free_blocks_reg;

    // Datapath helpers
    logic                                accept;
    logic [CNT_W-1:0]                    pop_pos;
    logic [CNT_W-1:0]                    cap_new;
    logic [PROD_W-1:0]                   product;

    fbsa_pkg::mem_ctrl_t                 mem_ctrl;
    logic [IDX_W-1:0]                    mem_addr;
    logic [IDX_W-1:0]                    mem_wdata;
    logic [IDX_W-1:0]                    mem_rdata;

    logic                                div_start;
    logic [fbsa_pkg::OFFSET_W-1:0]       div_dividend;
    logic [DIV_W-1:0]                    div_divisor;
    logic [fbsa_pkg::OFFSET_W-1:0]       div_quotient;
    fbsa_pkg::div_stat_t                 div_stat;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pop_pos  = top_reg - 1'b1;
    assign product  = PROD_W'(idx_reg) * PROD_W'(words_reg);

    // pool_count is taken from the low COUNT_W bits of cfg_data; above MAX_BLOCKS it saturates
    assign cap_new = (int'(cfg_data[CNT_W-1:0]) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                             : cfg_data[CNT_W-1:0];

    // Stack RAM: pop reads at accept, push writes in S_WRITE
    always_comb
    begin
        mem_ctrl.rd_en = 1'b0;
        mem_ctrl.wr_en = 1'b0;
        mem_addr       = IDX_W'(pop_pos);
        mem_wdata      = idx_reg;
        if (accept && (req_type == fbsa_pkg::REQ_ALLOC) && (top_reg != '0)
            && (pop_pos >= min_top_reg))
        begin
            mem_ctrl.rd_en = 1'b1;
        end
        if (state_reg == S_WRITE)
        begin
            mem_ctrl.wr_en = 1'b1;
            mem_addr       = IDX_W'(top_reg);
        end
    end

    // Divider: offset / words; the index keeps the low quotient bits
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = free_word_offset;
        div_divisor  = words_reg;
        if (accept && (req_type == fbsa_pkg::REQ_FREE) && (top_reg < cap_reg))
        begin
            div_start = 1'b1;
        end
    end

    fbsa_stack_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (IDX_W)
    ) u_stack_mem (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fbsa_div #(
        .DIVISOR_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .stat      (div_stat)
    );

    // Control FSM, pool state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            words_reg             <= WORD_W'(fbsa_pkg::words_per_object(
                                         fbsa_pkg::RESET_OBJECT_BYTES, MAX_OBJECT_WORDS));
            cap_reg               <= '0;
            top_reg               <= '0;
            min_top_reg           <= '0;
            idx_reg               <= '0;
            res_status_reg        <= fbsa_pkg::STATUS_OK;
            res_offset_reg        <= '0;
            out_valid_reg         <= 1'b0;
            status_reg            <= fbsa_pkg::STATUS_OK;
            block_word_offset_reg <= '0;
            free_blocks_reg       <= '0;
        end
        else
        begin
            // the user must make register writes only while idle; the block itself does not enforce it
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    fbsa_pkg::REG_OBJECT_BYTES:
                    begin
                        words_reg <= WORD_W'(fbsa_pkg::words_per_object(
                                         cfg_data[fbsa_pkg::BYTES_W-1:0], MAX_OBJECT_WORDS));
                    end
                    fbsa_pkg::REG_POOL_COUNT:
                    begin
                        cap_reg     <= cap_new;
                        top_reg     <= cap_new;
                        min_top_reg <= cap_new;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // S_FINISH reloads the slot itself when it drains
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_offset_reg <= '0;
                        if (req_type == fbsa_pkg::REQ_ALLOC)
                        begin
                            if (top_reg == '0)
                            begin
                                res_status_reg <= fbsa_pkg::STATUS_EMPTY;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                res_status_reg <= fbsa_pkg::STATUS_OK;
                                top_reg        <= pop_pos;
                                if (pop_pos < min_top_reg)
                                begin
                                    // slot untouched since restart
                                    idx_reg     <= IDX_W'(pop_pos);
                                    min_top_reg <= pop_pos;
                                    state_reg   <= S_MUL;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                        end
                        else
                        begin
                            if (top_reg >= cap_reg)
                            begin
                                res_status_reg <= fbsa_pkg::STATUS_FULL;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                res_status_reg <= fbsa_pkg::STATUS_OK;
                                state_reg      <= S_DIV;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    idx_reg   <= mem_rdata;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    res_offset_reg <= fbsa_pkg::OFFSET_W'(product);
                    state_reg      <= S_FINISH;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        idx_reg   <= IDX_W'(div_quotient);
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    top_reg   <= top_reg + 1'b1;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg         <= 1'b1;
                        status_reg            <= res_status_reg;
                        block_word_offset_reg <= res_offset_reg;
                        free_blocks_reg       <= top_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign block_word_offset = block_word_offset_reg;
    assign free_blocks       = free_blocks_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `FBSA_ASSERT(a_top_within_cap, top_reg <= cap_reg, "free count above capacity")
    `FBSA_ASSERT(a_mark_below_top, min_top_reg <= top_reg, "low-water mark above stack top")
    `FBSA_ASSERT_IMPL(a_push_in_range, mem_ctrl.wr_en, top_reg < cap_reg, "push past capacity")
    `FBSA_ASSERT_IMPL(a_idle_div_quiet, state_reg == S_IDLE, !div_stat.busy,
                      "divider busy in idle")
    `FBSA_ASSERT_IMPL(a_empty_result,
                      out_valid_reg && (status_reg == fbsa_pkg::STATUS_EMPTY),
                      (block_word_offset_reg == '0) && (free_blocks_reg == '0),
                      "empty result carries data")

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - free stack block allocator testbench
// Drives allocate and free transactions through the valid/ready request
// channel, rewrites object size and pool size between phases, and checks
// every result against a cycle-free model of the free index stack.
// ----------------------------------------------------------------------------
module tb_top;

    import fbsa_pkg::*;

    localparam int POOL_LIMIT    = DEF_MAX_BLOCKS;
    localparam int WORD_LIMIT    = DEF_MAX_OBJECT_WORDS;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    // longest free (a full divider pass) plus margin
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 136;
    // one long receiver hold-off once this many results have been checked
    localparam int HOLD_AT       = 500;
    localparam int LONG_HOLD     = 400;

    // expected content of one result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  free_cnt;
    } pool_reply_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and the free index
    // stack, predicts the result of each accepted request and queues it.
    // ------------------------------------------------------------------------
    class pool_scoreboard;
        logic [BYTES_W-1:0] obj_bytes;
        logic [COUNT_W-1:0] pool_cnt;
        logic [9:0]         idx_stack [POOL_LIMIT];
        logic [COUNT_W-1:0] top;
        pool_reply_t        expected_replies [$];
        int n_alloc, n_free, n_ok, n_empty, n_full, n_checked, n_errors;

        function new();
            n_alloc   = 0;
            n_free    = 0;
            n_ok      = 0;
            n_empty   = 0;
            n_full    = 0;
            n_checked = 0;
            n_errors  = 0;
            obj_bytes = RESET_OBJECT_BYTES;
            pool_cnt  = '0;
            restart_stack();
        endfunction

        function int unsigned capacity();
            return (pool_cnt > POOL_LIMIT) ? POOL_LIMIT : pool_cnt;
        endfunction

        // ceil(bytes / 4); zero size counts as one word, large sizes saturate
        function int unsigned words();
            int unsigned w;
            w = (int'(obj_bytes) + 3) / 4;
            if (w == 0)
            begin
                w = 1;
            end
            if (w > WORD_LIMIT)
            begin
                w = WORD_LIMIT;
            end
            return w;
        endfunction

        function void restart_stack();
            for (int i = 0; i < POOL_LIMIT; i++)
            begin
                idx_stack[i] = 10'(i);
            end
            top = COUNT_W'(capacity());
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_OBJECT_BYTES)
            begin
                obj_bytes = data[BYTES_W-1:0];
            end
            else if (idx == REG_POOL_COUNT)
            begin
                pool_cnt = data[COUNT_W-1:0];
                restart_stack();
            end
        endfunction

        function pool_reply_t log_request(logic req, logic [OFFSET_W-1:0] offs);
            pool_reply_t r;
            int unsigned w;
            int unsigned prod;
            int unsigned quot;
            w        = words();
            r.status = STATUS_OK;
            r.offset = '0;
            if (req == REQ_ALLOC)
            begin
                n_alloc++;
                if (top > 0)
                begin
                    top      = top - 1'b1;
                    prod     = int'(idx_stack[top[9:0]]) * w;
                    r.offset = prod[OFFSET_W-1:0];
                end
                else
                begin
                    r.status = STATUS_EMPTY;
                end
            end
            else
            begin
                n_free++;
                if (top >= capacity())
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    // index wraps at the stack entry width, no ownership check
                    quot                 = int'(offs) / w;
                    idx_stack[top[9:0]] = quot[9:0];
                    top                  = top + 1'b1;
                end
            end
            r.free_cnt = top;
            case (r.status)
                STATUS_OK:    n_ok++;
                STATUS_EMPTY: n_empty++;
                default:      n_full++;
            endcase
            expected_replies.push_back(r);
            return r;
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [OFFSET_W-1:0] offs,
                                  logic [COUNT_W-1:0] fb);
            pool_reply_t e;
            n_checked++;
            if (expected_replies.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result: status %0d offset %0d free %0d",
                         $time, st, offs, fb);
                return;
            end
            e = expected_replies.pop_front();
            if (st !== e.status)
            begin
                n_errors++;
                $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
            end
            if (offs !== e.offset)
            begin
                n_errors++;
                $display("%0t: block_word_offset mismatch: expected %0d actual %0d",
                         $time, e.offset, offs);
            end
            if (fb !== e.free_cnt)
            begin
                n_errors++;
                $display("%0t: free_blocks mismatch: expected %0d actual %0d",
                         $time, e.free_cnt, fb);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  req_type;
    logic [OFFSET_W-1:0]   free_word_offset;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [OFFSET_W-1:0]   block_word_offset;
    logic [COUNT_W-1:0]    free_blocks;

    fixed_block_free_stack_allocator_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .free_word_offset  (free_word_offset),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .block_word_offset (block_word_offset),
        .free_blocks       (free_blocks)
    );

    pool_scoreboard      sb;
    // offsets handed out by successful allocates, used to build real frees
    logic [OFFSET_W-1:0] held_offsets [$];
    // no random idling gaps on either side while set (the long hold-off still applies)
    bit                  steady;
    int                  alloc_pct;
    int                  cycle_cnt;
    int                  phases_run;

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result transactions are checked at the edge that accepts them
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            sb.check_reply(status, block_word_offset, free_blocks);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OFFSET_W-1:0] rand_offset();
        return OFFSET_W'($urandom);
    endfunction

    // mostly small sizes so pools cycle through empty and full
    function automatic logic [CFG_DATA_W-1:0] pick_object_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return CFG_DATA_W'($urandom_range(0, 16));
        end
        else if (r < 70)
        begin
            return CFG_DATA_W'($urandom_range(17, 512));
        end
        else if (r < 85)
        begin
            return CFG_DATA_W'($urandom_range(513, 4096));
        end
        return CFG_DATA_W'($urandom_range(4097, 8191));
    endfunction

    // upper data bits above the register width are dropped by the block
    function automatic logic [CFG_DATA_W-1:0] pick_pool_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return CFG_DATA_W'($urandom_range(0, 8));
        end
        else if (r < 60)
        begin
            return CFG_DATA_W'($urandom_range(9, 64));
        end
        else if (r < 75)
        begin
            return CFG_DATA_W'($urandom_range(65, POOL_LIMIT - 1));
        end
        else if (r < 85)
        begin
            return CFG_DATA_W'(POOL_LIMIT);
        end
        return CFG_DATA_W'($urandom_range(POOL_LIMIT + 1, 8191));
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // drop valid for a gap of length g; g of zero keeps valid up for the next request
    task automatic pause_sender(int g);
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic send_request(logic req, logic [OFFSET_W-1:0] offs);
        pool_reply_t exp_reply;
        @(negedge clk);
        in_valid         <= 1'b1;
        req_type         <= req;
        free_word_offset <= offs;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        exp_reply = sb.log_request(req, offs);
        if (req == REQ_ALLOC && exp_reply.status == STATUS_OK)
        begin
            held_offsets.push_back(exp_reply.offset);
        end
    endtask

    task automatic issue(logic req, logic [OFFSET_W-1:0] offs);
        pause_sender(steady ? 0 : pick_gap());
        send_request(req, offs);
    endtask

    // block idle: nothing outstanding, then enough cycles for any free in flight
    task automatic settle();
        pause_sender(1);
        while (sb.expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        if (idx == REG_POOL_COUNT)
        begin
            held_offsets.delete();
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // one random request: mostly allocates and frees of live blocks,
    // the rest frees of arbitrary or foreign offsets
    task automatic random_item();
        int r;
        int k;
        int unsigned w;
        logic [OFFSET_W-1:0] offs;
        r    = $urandom_range(0, 99);
        w    = sb.words();
        offs = rand_offset();
        if (r < alloc_pct)
        begin
            issue(REQ_ALLOC, offs);
        end
        else if (r < 90 && held_offsets.size() > 0)
        begin
            k    = $urandom_range(0, held_offsets.size() - 1);
            offs = held_offsets[k];
            held_offsets.delete(k);
            // pointer into the middle of the block truncates to the same index
            if ($urandom_range(0, 1) == 1)
            begin
                offs = offs + OFFSET_W'($urandom_range(0, w - 1));
            end
            issue(REQ_FREE, offs);
        end
        else if (r < 95)
        begin
            issue(REQ_FREE, offs);
        end
        else
        begin
            issue(REQ_FREE, OFFSET_W'($urandom_range(0, POOL_LIMIT - 1) * w));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random ready gaps, one long hold-off that backs the
    // block up while the sender keeps offering requests
    // ------------------------------------------------------------------------
    initial
    begin
        bit long_done;
        int g;
        long_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!long_done && sb.n_checked >= HOLD_AT)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_done = 1'b1;
            end
            else
            begin
                g = steady ? 0 : pick_gap();
                if (g > 0)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
                @(negedge clk);
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_OBJECT_BYTES;
        cfg_data         = '0;
        in_valid         = 1'b0;
        req_type         = REQ_ALLOC;
        free_word_offset = '0;
        steady           = 1'b0;
        alloc_pct        = 50;
        cycle_cnt        = 0;
        phases_run       = 0;
        sb               = new();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: zero pool, so allocate finds it empty and
        // free finds the stack already full
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_FREE, '0);

        // zero object size acts as one word; three blocks
        settle();
        write_reg(REG_OBJECT_BYTES, '0);
        write_reg(REG_POOL_COUNT, CFG_DATA_W'(3));
        repeat (3) issue(REQ_ALLOC, rand_offset());
        issue(REQ_ALLOC, rand_offset());          // drained pool
        issue(REQ_FREE, OFFSET_W'(2));
        issue(REQ_FREE, '1);                      // foreign offset wraps the index
        issue(REQ_FREE, OFFSET_W'(1));
        issue(REQ_FREE, '0);                      // stack full
        issue(REQ_ALLOC, rand_offset());

        // size change alone keeps the stack; widest size saturates
        settle();
        write_reg(REG_OBJECT_BYTES, '1);
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_FREE, '1);

        // pool register value past the stack depth saturates capacity
        settle();
        write_reg(REG_OBJECT_BYTES, CFG_DATA_W'(4093));
        write_reg(REG_POOL_COUNT, '1);
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_FREE, OFFSET_W'(POOL_LIMIT));
        issue(REQ_FREE, OFFSET_W'(5));            // full at capacity

        // two-word objects, full-depth pool, truncating free
        settle();
        write_reg(REG_OBJECT_BYTES, CFG_DATA_W'(5));
        write_reg(REG_POOL_COUNT, CFG_DATA_W'(POOL_LIMIT));
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_FREE, OFFSET_W'(3));
        issue(REQ_ALLOC, rand_offset());

        // single block pool
        settle();
        write_reg(REG_OBJECT_BYTES, CFG_DATA_W'(1));
        write_reg(REG_POOL_COUNT, CFG_DATA_W'(1));
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_ALLOC, rand_offset());
        issue(REQ_FREE, OFFSET_W'(20'hAAAAA));
        issue(REQ_FREE, OFFSET_W'(20'h55555));

        // random phases: each one picks sizes, a request mix and an idling style;
        // some phases keep the old pool so only the scaling changes
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            write_reg(REG_OBJECT_BYTES, pick_object_bytes());
            if (ph == 0 || $urandom_range(0, 3) != 0)
            begin
                write_reg(REG_POOL_COUNT, pick_pool_count());
            end
            steady    = (ph % 4 == 3);
            alloc_pct = (ph % 3 == 0) ? 35 : ((ph % 3 == 1) ? 50 : 65);
            repeat (PHASE_ITEMS) random_item();
            phases_run++;
        end
        steady = 1'b0;

        settle();
        $display("tb_top: %0d requests (%0d allocate, %0d free) over %0d random phases",
                 sb.n_alloc + sb.n_free, sb.n_alloc, sb.n_free, phases_run);
        $display("tb_top: %0d results checked: %0d ok, %0d pool empty, %0d stack full",
                 sb.n_checked, sb.n_ok, sb.n_empty, sb.n_full);
        if (sb.n_errors == 0 && sb.expected_replies.size() == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/fbsa_pkg.sv
rtl/core/fbsa_stack_mem.sv
rtl/core/fbsa_div.sv
rtl/core/fixed_block_free_stack_allocator_top.sv
verif/tb_top.sv
